>>> rtl/core/imtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imtb_pkg: shared constants of the iterative mean threshold binarizer
// Holds the region and histogram sizes, reset values and sequencer state codes.
// ----------------------------------------------------------------------------
package imtb_pkg;

  localparam int unsigned MaxRegionPixels = 1048576;
  localparam int unsigned NumBins         = 256;
  localparam logic [7:0]  MaxIterReset    = 8'd50;
  localparam logic [7:0]  GrayMax         = 8'd255;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRdBin  = 4'd1;
  localparam logic [3:0] StWrBin  = 4'd2;
  localparam logic [3:0] StStart  = 4'd3;
  localparam logic [3:0] StAcc    = 4'd4;
  localparam logic [3:0] StDiv    = 4'd5;
  localparam logic [3:0] StStep   = 4'd6;
  localparam logic [3:0] StClear  = 4'd7;

endpackage

>>> rtl/core/iterative_mean_threshold_binarizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_mean_threshold_binarizer_unit: isodata threshold and binarizer
// Histogram gather, iterative mean threshold search and sample binarize.
// ----------------------------------------------------------------------------
// Usage: samples enter on the in channel (in_valid_i / in_stall_o) with
// action, pixel and last. Results leave on the out channel (out_valid_o /
// out_stall_i). A gather sample without last gives no result and takes
// one histogram memory read and one write. A binarize sample gives one
// registered result. A gather sample with last starts the search:
// each refinement sweeps the histogram memory once, one bin a cycle, over
// the bins min..max (at most 256), then runs a 37-step restoring divider
// twice; up to max_iterations refinements run (a zero limit acts as one).
// After the report the histogram is cleared by a sweep over all 256 bins.
// After reset a clearing pass over all 256 bins runs before the first
// sample is taken; the configuration write port is always ready. A stalled
// result stays in the output register and the block takes no new sample
// until the result is transferred.
// ----------------------------------------------------------------------------
module iterative_mean_threshold_binarizer_unit #(
  parameter int unsigned MAX_REGION_PIXELS = imtb_pkg::MaxRegionPixels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] pixel_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] threshold_o,
  output logic [7:0] binary_value_o,
  output logic [7:0] iterations_used_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned BinW = $clog2(MAX_REGION_PIXELS + 1);
  localparam int unsigned CntW = BinW + 8;
  localparam int unsigned SumW = BinW + 16;
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW = $clog2(DivSteps + 1);

  logic [BinW-1:0] mem_q [imtb_pkg::NumBins];
  logic [BinW-1:0] rd_q;
  logic [7:0]      addr_q, addr_d;
  logic            we;
  logic [BinW-1:0] wdata;

  logic [3:0] st_q, st_d;
  logic [7:0] min_q, min_d, max_q, max_d, thr_q, thr_d;
  logic [7:0] t_q, t_d, iter_q, iter_d, maxit_q;
  logic [8:0] m1_q, m1_d;
  logic       pass_q, pass_d;  // 0: lower class divide, 1: upper; holds last during a gather
  logic       rdv_q, rdv_d;    // read data valid during sweep
  logic       swdone_q, swdone_d;
  logic [SumW-1:0] s1_q, s1_d, s2_q, s2_d;
  logic [CntW-1:0] c1_q, c1_d, c2_q, c2_d;
  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic       ov_q, ov_d;
  logic       okind_q, okind_d;
  logic [7:0] othr_q, othr_d, obin_q, obin_d, oit_q, oit_d;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr_q] <= wdata;
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= imtb_pkg::StClear;
      addr_q <= '0;
      min_q <= imtb_pkg::GrayMax;
      max_q <= '0;
      thr_q <= '0;
      maxit_q <= imtb_pkg::MaxIterReset;
      ov_q <= 1'b0;
      rdv_q <= 1'b0;
      swdone_q <= 1'b0;
    end else begin
      st_q <= st_d;
      addr_q <= addr_d;
      min_q <= min_d;
      max_q <= max_d;
      thr_q <= thr_d;
      ov_q <= ov_d;
      rdv_q <= rdv_d;
      swdone_q <= swdone_d;
      if (cfg_valid_i) maxit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; iter_q <= iter_d; m1_q <= m1_d; pass_q <= pass_d;
    s1_q <= s1_d; s2_q <= s2_d; c1_q <= c1_d; c2_q <= c2_d;
    quo_q <= quo_d; rem_q <= rem_d; step_q <= step_d;
    okind_q <= okind_d; othr_q <= othr_d; obin_q <= obin_d; oit_q <= oit_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != imtb_pkg::StIdle) || ov_q;
  assign out_valid_o = ov_q;
  assign kind_o = okind_q;
  assign threshold_o = othr_q;
  assign binary_value_o = obin_q;
  assign iterations_used_o = oit_q;

  logic [7:0] limit;
  logic [8:0] nt;
  logic [CntW:0] trial;
  logic [SumW-1:0] prod;
  logic [7:0] mean8;
  logic [7:0] bin_idx;
  assign limit = (maxit_q == 8'd0) ? 8'd1 : maxit_q;
  assign bin_idx = addr_q - 8'd1;

  always_comb begin
    st_d = st_q; addr_d = addr_q; min_d = min_q; max_d = max_q; thr_d = thr_q;
    t_d = t_q; iter_d = iter_q; m1_d = m1_q; pass_d = pass_q;
    s1_d = s1_q; s2_d = s2_q; c1_d = c1_q; c2_d = c2_q;
    quo_d = quo_q; rem_d = rem_q; step_d = step_q;
    ov_d = ov_q && out_stall_i; rdv_d = 1'b0; swdone_d = swdone_q;
    okind_d = okind_q; othr_d = othr_q; obin_d = obin_q; oit_d = oit_q;
    we = 1'b0; wdata = rd_q;
    prod = SumW'(rd_q) * SumW'(bin_idx);
    trial = {rem_q[CntW-1:0], (pass_q ? s2_q[SumW-1] : s1_q[SumW-1])};
    nt = '0; mean8 = quo_q[7:0];
    case (st_q)
      imtb_pkg::StIdle: begin
        if (in_valid_i && !ov_q) begin
          if (action_i) begin
            ov_d = 1'b1; okind_d = 1'b1; othr_d = thr_q; oit_d = '0;
            obin_d = (pixel_i <= thr_q) ? 8'd0 : imtb_pkg::GrayMax;
          end else begin
            pass_d = last_i; addr_d = pixel_i;
            if (pixel_i < min_q) min_d = pixel_i;
            if (pixel_i > max_q) max_d = pixel_i;
            st_d = imtb_pkg::StRdBin;
          end
        end
      end
      imtb_pkg::StRdBin: st_d = imtb_pkg::StWrBin;
      imtb_pkg::StWrBin: begin
        we = 1'b1;
        wdata = (rd_q < BinW'(MAX_REGION_PIXELS)) ? rd_q + 1'b1 : rd_q;
        if (pass_q) begin
          t_d = '0; iter_d = '0;
          nt = ({1'b0, min_q} + {1'b0, max_q}) >> 1;
          m1_d = nt;
          st_d = imtb_pkg::StStep;
        end else st_d = imtb_pkg::StIdle;
      end
      imtb_pkg::StStep: begin
        // m1_q holds the new threshold candidate here
        if (m1_q[7:0] != t_q && iter_q < limit) begin
          t_d = m1_q[7:0]; iter_d = iter_q + 1'b1;
          s1_d = '0; s2_d = '0; c1_d = '0; c2_d = '0;
          addr_d = min_q; rdv_d = 1'b0; swdone_d = 1'b0;
          st_d = imtb_pkg::StStart;
        end else begin
          thr_d = t_q; ov_d = 1'b1; okind_d = 1'b0; othr_d = t_q;
          obin_d = '0; oit_d = iter_q;
          min_d = imtb_pkg::GrayMax; max_d = '0; addr_d = '0;
          st_d = imtb_pkg::StClear;
        end
      end
      imtb_pkg::StStart: begin
        addr_d = addr_q + 1'b1; rdv_d = 1'b1;
        swdone_d = (addr_q == max_q);
        st_d = imtb_pkg::StAcc;
      end
      imtb_pkg::StAcc: begin
        // rd_q is the bin at addr_q-1
        if (rdv_q) begin
          if (bin_idx < t_q) begin
            s1_d = s1_q + prod; c1_d = c1_q + CntW'(rd_q);
          end else begin
            s2_d = s2_q + prod; c2_d = c2_q + CntW'(rd_q);
          end
        end
        if (!swdone_q) begin
          addr_d = addr_q + 1'b1; rdv_d = 1'b1;
          swdone_d = (addr_q == max_q);
        end else begin
          // dividend shifts through s1_q (s2_q in the upper pass), quotient builds in quo_q
          pass_d = 1'b0; rem_d = '0; quo_d = '0; step_d = '0;
          st_d = imtb_pkg::StDiv;
        end
      end
      imtb_pkg::StDiv: begin
        trial = {rem_q[CntW-1:0], (pass_q ? s2_q[SumW-1] : s1_q[SumW-1])};
        if (pass_q) s2_d = s2_q << 1; else s1_d = s1_q << 1;
        if (trial >= {1'b0, (pass_q ? c2_q : c1_q)}) begin
          rem_d = trial - {1'b0, (pass_q ? c2_q : c1_q)};
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = trial; quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          mean8 = quo_d[7:0];
          if (!pass_q) begin
            m1_d = {1'b0, (c1_q == '0) ? min_q : mean8};
            pass_d = 1'b1; rem_d = '0; quo_d = '0; step_d = '0;
          end else begin
            m1_d = (m1_q + {1'b0, (c2_q == '0) ? max_q : mean8}) >> 1;
            st_d = imtb_pkg::StStep;
          end
        end
      end
      imtb_pkg::StClear: begin
        we = 1'b1; wdata = '0; addr_d = addr_q + 1'b1;
        if (addr_q == 8'd255) st_d = imtb_pkg::StIdle;
      end
      default: st_d = imtb_pkg::StIdle;
    endcase
  end

endmodule

>>> bench/tb_iterative_mean_threshold_binarizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterative_mean_threshold_binarizer_unit: self-checking bench
// Streams gather regions and binarize samples through the unit, predicts
// every threshold report and binarized sample, and compares them in order.
// The iteration limit is written at the start of each phase, with no sample in flight.
// ----------------------------------------------------------------------------
module tb_iterative_mean_threshold_binarizer_unit;

  localparam int unsigned WatchLimit = 400000;
  localparam logic        ActGather  = 1'b0;
  localparam logic        ActBinar   = 1'b1;
  localparam logic        KindReport = 1'b0;
  localparam logic        KindSample = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
    logic       last;
  } sample_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] threshold;
    logic [7:0] binary_value;
    logic [7:0] iterations_used;
  } outcome_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i = 1'b0;
  logic [7:0] pixel_i = '0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       kind_o;
  logic [7:0] threshold_o;
  logic [7:0] binary_value_o;
  logic [7:0] iterations_used_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  iterative_mean_threshold_binarizer_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sample_t  pixel_q[$];
  outcome_t outcome_q[$];
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned report_cnt = 0;
  int unsigned binar_cnt = 0;
  int unsigned idle_cycles = 0;

  // predictor state
  int unsigned hist[256];
  logic [7:0]  gmin;
  logic [7:0]  gmax;
  logic [7:0]  cur_thr;
  logic [7:0]  iter_limit;

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  function automatic int unsigned class_avg(int unsigned lo, int unsigned hi_excl,
                                            int unsigned empty_val);
    longint unsigned sum;
    longint unsigned cnt;
    sum = 0;
    cnt = 0;
    for (int unsigned g = lo; g < hi_excl && g < 256; g++) begin
      sum += longint'(hist[g]) * g;
      cnt += hist[g];
    end
    if (cnt == 0) return empty_val;
    return 32'((sum / cnt) & 64'hFF);
  endfunction

  function automatic void clear_gather();
    foreach (hist[g]) hist[g] = 0;
    gmin = imtb_pkg::GrayMax;
    gmax = '0;
  endfunction

  // returns 1 when the sample produces a result
  function automatic bit threshold_step(sample_t s, output outcome_t o);
    int unsigned lim, lo, hi, t, nt, n, m1, m2;
    o = '0;
    if (s.action == ActBinar) begin
      o.kind = KindSample;
      o.threshold = cur_thr;
      o.binary_value = (s.pixel <= cur_thr) ? 8'd0 : 8'd255;
      return 1'b1;
    end
    if (hist[s.pixel] < imtb_pkg::MaxRegionPixels) hist[s.pixel]++;
    if (s.pixel < gmin) gmin = s.pixel;
    if (s.pixel > gmax) gmax = s.pixel;
    if (!s.last) return 1'b0;
    lim = (iter_limit == 0) ? 1 : iter_limit;
    lo = gmin;
    hi = gmax;
    t = 0;
    nt = (lo + hi) / 2;
    n = 0;
    while (t != nt && n < lim) begin
      t = nt;
      m1 = class_avg(lo, t, lo);
      m2 = class_avg(t, hi + 1, hi);
      nt = (m1 + m2) / 2;
      n++;
    end
    cur_thr = t[7:0];
    o.kind = KindReport;
    o.threshold = cur_thr;
    o.iterations_used = n[7:0];
    clear_gather();
    return 1'b1;
  endfunction

  // driver: presents queued samples, holds a stalled one
  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (threshold_step('{action_i, pixel_i, last_i}, o)) outcome_q.push_back(o);
        sent_cnt++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          sample_t s;
          s = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= s.action;
          pixel_i <= s.pixel;
          last_i <= s.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // monitor: checks every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = outcome_q.pop_front();
        if (kind_o !== e.kind) report("kind", kind_o, e.kind);
        if (threshold_o !== e.threshold) report("threshold", threshold_o, e.threshold);
        if (binary_value_o !== e.binary_value)
          report("binary_value", binary_value_o, e.binary_value);
        if (iterations_used_o !== e.iterations_used)
          report("iterations_used", iterations_used_o, e.iterations_used);
        if (e.kind == KindReport) report_cnt++;
        else binar_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results pending", outcome_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push(logic act, logic [7:0] pix, logic lst);
    pixel_q.push_back('{act, pix, lst});
  endtask

  task automatic push_region(int unsigned len, int unsigned base, int unsigned span);
    int unsigned p;
    for (int unsigned k = 0; k < len; k++) begin
      p = base + $urandom_range(0, span);
      push(ActGather, (p > 255) ? 8'd255 : p[7:0], k == len - 1);
    end
  endtask

  task automatic write_limit(logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    iter_limit = val;
    cfg_valid_i <= 1'b0;
  endtask

  // waits until every sample is sent, every result is back and the unit is idle
  task automatic drain();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || outcome_q.size() != 0 || in_stall_o);
  endtask

  task automatic random_items(int unsigned target);
    int unsigned n0, r, len;
    n0 = pixel_q.size();
    while (pixel_q.size() - n0 < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        push_region(len, $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 8)) push(ActBinar, 8'($urandom()), 1'($urandom()));
      end else begin
        push(ActGather, 8'($urandom()), 1'($urandom()));
      end
    end
  endtask

  logic [7:0] limits[6] = '{8'd50, 8'd0, 8'd1, 8'd255, 8'd2, 8'd0};

  initial begin
    clear_gather();
    cur_thr = '0;
    iter_limit = imtb_pkg::MaxIterReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    limits[5] = 8'($urandom_range(3, 254));
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin snd_idle_pct = 28; rcv_idle_pct = 76; end
        1: begin snd_idle_pct = 76; rcv_idle_pct = 28; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      write_limit(limits[ph]);
      if (ph == 0) begin
        // binarize before any report uses threshold zero
        push(ActBinar, 8'd0, 1'b0);
        push(ActBinar, 8'd255, 1'b1);
        // lone zero sample: search ends at once
        push(ActGather, 8'd0, 1'b1);
        push(ActGather, 8'd255, 1'b0);
        push(ActGather, 8'd0, 1'b1);
        push(ActBinar, 8'd127, 1'b0);
        push(ActBinar, 8'd128, 1'b0);
        push(ActBinar, 8'd255, 1'b0);
        // flat region leaves the lower class empty
        push(ActGather, 8'd100, 1'b0);
        push(ActGather, 8'd100, 1'b0);
        push(ActGather, 8'd100, 1'b1);
        push(ActBinar, 8'd100, 1'b0);
        push(ActBinar, 8'd101, 1'b0);
        push(ActGather, 8'd10, 1'b0);
        push(ActGather, 8'd250, 1'b0);
        push(ActGather, 8'd30, 1'b0);
        push(ActGather, 8'd200, 1'b1);
        push(ActBinar, 8'd0, 1'b0);
        push(ActBinar, 8'd255, 1'b0);
        push(ActGather, 8'd255, 1'b1);
        push(ActBinar, 8'd254, 1'b0);
      end
      random_items(140);
      drain();
    end
    $display("covered %0d samples, %0d threshold reports, %0d binarized samples",
             sent_cnt, report_cnt, binar_cnt);
    $display("iteration limits 0, 1, 2, 50, 255 and one random value, under three stall mixes");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/imtb_pkg.sv
rtl/core/iterative_mean_threshold_binarizer_unit.sv
bench/tb_iterative_mean_threshold_binarizer_unit.sv
